// ===== hw/rtl/bitmap_frame_allocator_assert.svh =====
// assertion helpers shared by the allocator rtl
`ifndef BITMAP_FRAME_ALLOCATOR_ASSERT_SVH
`define BITMAP_FRAME_ALLOCATOR_ASSERT_SVH

// same-cycle implication, checked outside reset
`define BFA_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked outside reset
`define BFA_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/bfa_pkg.sv =====
package bfa_pkg;

	localparam int MAX_FRAMES_DEF  = 65536;
	localparam int FRAME_BYTES_DEF = 4096;

	localparam int KIND_W  = 2;
	localparam int FIDX_W  = 16;
	localparam int BADDR_W = 32;
	localparam int CNT_W   = 17;
	localparam int WORD_W  = 32;
	localparam int BIT_W   = 5;
	localparam int LW_W    = CNT_W - BIT_W;
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;
	localparam int REG_IDX_W = PADDR_W - 2;

	localparam logic [REG_IDX_W-1:0] REG_FRAME_COUNT = REG_IDX_W'(0);

	typedef enum logic [KIND_W-1:0] {
		KIND_ALLOC   = 2'd0,
		KIND_FREE    = 2'd1,
		KIND_RESERVE = 2'd2,
		KIND_RELEASE = 2'd3
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_PREP,
		ST_FREE_WR,
		ST_ALLOC,
		ST_RUN,
		ST_RESP
	} state_t;

	typedef struct packed {
		logic [FIDX_W-1:0] frame;
		logic              found;
	} res_t;

	// index of the lowest set bit, 0 when none
	function automatic logic [BIT_W-1:0] lowest_bit(input logic [WORD_W-1:0] v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = BIT_W'(i);
			end
		end
		return idx;
	endfunction

endpackage

// ===== hw/rtl/bfa_if.sv =====
interface bfa_req_if;
	import bfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [KIND_W-1:0]   kind;
	logic [FIDX_W-1:0]   frame_index;
	logic [BADDR_W-1:0]  region_start;
	logic [BADDR_W-1:0]  region_end;

	modport source (output valid, kind, frame_index, region_start, region_end, input ready);
	modport sink (input valid, kind, frame_index, region_start, region_end, output ready);
endinterface

interface bfa_rsp_if;
	import bfa_pkg::*;

	logic                valid;
	logic                ready;
	logic [FIDX_W-1:0]   allocated_frame;
	logic                found;

	modport source (output valid, allocated_frame, found, input ready);
	modport sink (input valid, allocated_frame, found, output ready);
endinterface

// ===== hw/rtl/bfa_ram.sv =====
module bfa_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 2048,
	parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// ===== hw/rtl/bfa_regs.sv =====
module bfa_regs #(
	parameter int MAX_FRAMES = bfa_pkg::MAX_FRAMES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0] paddr,
	input  logic [bfa_pkg::PDATA_W-1:0] pwdata,
	output logic [bfa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready,
	output logic [bfa_pkg::CNT_W-1:0]   limit
);
	import bfa_pkg::*;

	logic [CNT_W-1:0]     frame_count_q;
	logic [REG_IDX_W-1:0] reg_idx;

	assign reg_idx = paddr[PADDR_W-1:2];
	assign pready  = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_count_q <= '0;
		end else if (psel && penable && pwrite && reg_idx == REG_FRAME_COUNT) begin
			frame_count_q <= pwdata[CNT_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_idx == REG_FRAME_COUNT) begin
			prdata = PDATA_W'(frame_count_q);
		end
	end

	// search limit saturates at the map size
	assign limit = (32'(frame_count_q) < 32'(MAX_FRAMES)) ? frame_count_q : CNT_W'(MAX_FRAMES);
endmodule

// ===== hw/rtl/bfa_ctrl.sv =====
`include "bitmap_frame_allocator_assert.svh"

module bfa_ctrl #(
	parameter int MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
	parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic [bfa_pkg::CNT_W-1:0] limit,
	bfa_req_if.sink                   req,
	output logic                      done,
	output bfa_pkg::res_t             res,
	input  logic                      res_take
);
	import bfa_pkg::*;

	localparam int MAP_WORDS = (MAX_FRAMES + WORD_W - 1) / WORD_W;
	localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
	localparam int FB_SH     = $clog2(FRAME_BYTES);
	localparam int FS_W      = BADDR_W - FB_SH;
	localparam int FE_W      = BADDR_W + 1 - FB_SH;
	localparam int SC_W      = LW_W + 1;

	state_t state_q, state_d;

	kind_t             kind_q;
	logic [FIDX_W-1:0] fidx_q;
	logic [FS_W-1:0]   fs_q;
	logic [FE_W-1:0]   fe_q;
	logic [BADDR_W:0]  fe_full;

	logic [LW_W-1:0]   wf_q, wl_q;
	logic [BIT_W-1:0]  lo_q, hi_q;
	logic              set_q;

	logic [SC_W-1:0]   ptr_q;
	logic              vld_s1;
	logic [LW_W-1:0]   word_s1;
	logic [AW-1:0]     clr_q;

	logic              ram_we, ram_re, issue, accept;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [WORD_W-1:0] ram_wdata, ram_rdata;

	logic [CNT_W-1:0]  fe_clip, first_f, last_f;
	logic              span_ok, free_ok, alloc_more, run_more, hit;
	logic [WORD_W-1:0] lim_mask, avail, span_mask, free_bit;
	logic [BIT_W-1:0]  hit_bit, lo_eff, hi_eff;

	logic              res_load;
	res_t              res_d, res_q;

	bfa_ram #(
		.WIDTH(WORD_W),
		.DEPTH(MAP_WORDS),
		.AW   (AW)
	) u_map (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	assign req.ready = (state_q == ST_IDLE);
	assign accept    = req.valid && req.ready;
	assign done      = (state_q == ST_RESP);
	assign res       = res_q;
	assign fe_full   = (BADDR_W + 1)'(req.region_end) + (BADDR_W + 1)'(FRAME_BYTES - 1);

	// region span clipped to the limit
	assign fe_clip = (fe_q > FE_W'(limit)) ? limit : CNT_W'(fe_q);
	assign span_ok = FE_W'(fs_q) < FE_W'(fe_clip);
	assign first_f = CNT_W'(fs_q);
	assign last_f  = fe_clip - CNT_W'(1);
	assign free_ok = CNT_W'(fidx_q) < limit;

	// allocate scan: free bits of the word in flight, masked at the limit
	assign alloc_more = {ptr_q, BIT_W'(0)} < (SC_W + BIT_W)'(limit);
	assign lim_mask   = (limit[CNT_W-1:BIT_W] == word_s1)
		? ((WORD_W'(1) << limit[BIT_W-1:0]) - WORD_W'(1)) : '1;
	assign avail      = ~ram_rdata & lim_mask;
	assign hit        = vld_s1 && (avail != '0);
	assign hit_bit    = lowest_bit(avail);

	// region walk: partial masks on the first and last words
	assign run_more  = ptr_q <= SC_W'(wl_q);
	assign lo_eff    = (word_s1 == wf_q) ? lo_q : '0;
	assign hi_eff    = (word_s1 == wl_q) ? hi_q : '1;
	assign span_mask = ({WORD_W{1'b1}} >> (BIT_W'(WORD_W - 1) - hi_eff))
		& ({WORD_W{1'b1}} << lo_eff);
	assign free_bit  = WORD_W'(1) << fidx_q[BIT_W-1:0];

	always_comb begin
		state_d   = state_q;
		ram_we    = 1'b0;
		ram_waddr = '0;
		ram_wdata = '0;
		ram_re    = 1'b0;
		ram_raddr = '0;
		issue     = 1'b0;
		res_load  = 1'b0;
		res_d     = '0;
		case (state_q)
			ST_CLEAR: begin
				ram_we    = 1'b1;
				ram_waddr = clr_q;
				ram_wdata = '1;
				if (clr_q == AW'(MAP_WORDS - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (accept) begin
					state_d = (kind_t'(req.kind) == KIND_ALLOC) ? ST_ALLOC : ST_PREP;
				end
			end
			ST_PREP: begin
				if (kind_q == KIND_FREE) begin
					if (free_ok) begin
						ram_re    = 1'b1;
						ram_raddr = AW'(fidx_q[FIDX_W-1:BIT_W]);
						state_d   = ST_FREE_WR;
					end else begin
						res_load = 1'b1;
						state_d  = ST_RESP;
					end
				end else if (span_ok) begin
					state_d = ST_RUN;
				end else begin
					res_load    = 1'b1;
					res_d.found = 1'b1;
					state_d     = ST_RESP;
				end
			end
			ST_FREE_WR: begin
				ram_we      = 1'b1;
				ram_waddr   = AW'(fidx_q[FIDX_W-1:BIT_W]);
				ram_wdata   = ram_rdata & ~free_bit;
				res_load    = 1'b1;
				res_d.found = 1'b1;
				state_d     = ST_RESP;
			end
			ST_ALLOC: begin
				if (hit) begin
					ram_we      = 1'b1;
					ram_waddr   = AW'(word_s1);
					ram_wdata   = ram_rdata | (WORD_W'(1) << hit_bit);
					res_load    = 1'b1;
					res_d.frame = FIDX_W'({word_s1, hit_bit});
					res_d.found = 1'b1;
					state_d     = ST_RESP;
				end else if (alloc_more) begin
					issue     = 1'b1;
					ram_re    = 1'b1;
					ram_raddr = AW'(ptr_q);
				end else if (!vld_s1) begin
					res_load = 1'b1;
					state_d  = ST_RESP;
				end
			end
			ST_RUN: begin
				if (run_more) begin
					issue     = 1'b1;
					ram_re    = 1'b1;
					ram_raddr = AW'(ptr_q);
				end
				if (vld_s1) begin
					ram_we    = 1'b1;
					ram_waddr = AW'(word_s1);
					ram_wdata = set_q ? (ram_rdata | span_mask) : (ram_rdata & ~span_mask);
					if (word_s1 == wl_q) begin
						res_load    = 1'b1;
						res_d.found = 1'b1;
						state_d     = ST_RESP;
					end
				end
			end
			ST_RESP: begin
				if (res_take) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			clr_q   <= '0;
			vld_s1  <= 1'b0;
		end else begin
			state_q <= state_d;
			vld_s1  <= issue;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + AW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= kind_t'(req.kind);
			fidx_q <= req.frame_index;
			fs_q   <= req.region_start[BADDR_W-1:FB_SH];
			fe_q   <= fe_full[BADDR_W:FB_SH];
			ptr_q  <= '0;
		end else if (state_q == ST_PREP) begin
			ptr_q <= SC_W'(first_f[CNT_W-1:BIT_W]);
		end else if (issue) begin
			ptr_q <= ptr_q + SC_W'(1);
		end
		if (state_q == ST_PREP) begin
			wf_q  <= first_f[CNT_W-1:BIT_W];
			wl_q  <= last_f[CNT_W-1:BIT_W];
			lo_q  <= first_f[BIT_W-1:0];
			hi_q  <= last_f[BIT_W-1:0];
			set_q <= (kind_q == KIND_RESERVE);
		end
		if (issue) begin
			word_s1 <= ptr_q[LW_W-1:0];
		end
		if (res_load) begin
			res_q <= res_d;
		end
	end

	`BFA_ASSERT_NOW(a_no_rw_clash, clk, arst_n, ram_we && ram_re, ram_waddr != ram_raddr,
		"map read and write hit the same word")
	`BFA_ASSERT_NOW(a_alloc_one_bit, clk, arst_n, ram_we && state_q == ST_ALLOC,
		$countones(ram_wdata) == $countones(ram_rdata) + 1, "allocate must set exactly one bit")
	`BFA_ASSERT_NOW(a_run_in_span, clk, arst_n, vld_s1 && state_q == ST_RUN,
		word_s1 >= wf_q && word_s1 <= wl_q, "region walk left its span")
	`BFA_ASSERT_NEXT(a_clear_blocks, clk, arst_n, state_q == ST_CLEAR && !ram_we,
		1'b0, "clearing pass skipped a word")
endmodule

// ===== hw/rtl/bitmap_frame_allocator.sv =====
// used map of MAP_WORDS 32-bit words in one registered-read ram, one request at a time
// reset: a clearing pass over all MAP_WORDS words marks all frames used, req.ready low
// allocate: reads map words from word zero up to the limit, granting the lowest free frame or reporting a miss
// free frame: clears its bit, not found when out of range; region: walks the words in its span, skipped when empty
// result waits in an output register; next request taken in the cycle after the hand-off, even unread
`include "bitmap_frame_allocator_assert.svh"

module bitmap_frame_allocator #(
	parameter int MAX_FRAMES  = bfa_pkg::MAX_FRAMES_DEF,
	parameter int FRAME_BYTES = bfa_pkg::FRAME_BYTES_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	bfa_req_if.sink                     req,
	bfa_rsp_if.source                   rsp,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [bfa_pkg::PADDR_W-1:0] paddr,
	input  logic [bfa_pkg::PDATA_W-1:0] pwdata,
	output logic [bfa_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import bfa_pkg::*;

	logic [CNT_W-1:0] limit;   // min(frame_count, MAX_FRAMES)
	logic             done;    // engine holds a finished result
	logic             res_take;
	res_t             res;

	// output register state
	logic              out_valid_q;
	logic [FIDX_W-1:0] out_frame_q;
	logic              out_found_q;

	// apb register file: frame_count only
	bfa_regs #(
		.MAX_FRAMES(MAX_FRAMES)
	) u_regs (
		.clk    (clk),
		.arst_n (arst_n),
		.psel   (psel),
		.penable(penable),
		.pwrite (pwrite),
		.paddr  (paddr),
		.pwdata (pwdata),
		.prdata (prdata),
		.pready (pready),
		.limit  (limit)
	);

	// request sequencer around the used-map ram
	bfa_ctrl #(
		.MAX_FRAMES (MAX_FRAMES),
		.FRAME_BYTES(FRAME_BYTES)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.limit   (limit),
		.req     (req),
		.done    (done),
		.res     (res),
		.res_take(res_take)
	);

	// the result moves over when the output slot is empty or being drained this cycle
	assign res_take = done && (!out_valid_q || rsp.ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_take) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			// transfer completed, slot empties
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res_take) begin
			out_frame_q <= res.frame;
			out_found_q <= res.found;
		end
	end

	assign rsp.valid           = out_valid_q;
	assign rsp.allocated_frame = out_frame_q;
	assign rsp.found           = out_found_q;

	// a miss or a non-allocate request always reports frame zero
	`BFA_ASSERT_NOW(a_miss_frame_zero, clk, arst_n, rsp.valid && !rsp.found,
		rsp.allocated_frame == '0, "frame must be zero without a grant")
	// a handed-over result is visible on the next cycle
	`BFA_ASSERT_NEXT(a_take_shows, clk, arst_n, res_take, rsp.valid,
		"result hand-off lost")
	// the sequencer never sits finished while the output slot is free
	`BFA_ASSERT_NOW(a_no_idle_slot, clk, arst_n, done && !out_valid_q, res_take,
		"finished result not moved to free output slot")
endmodule
